/* rtl/core/sgp_pkg.sv */
package sgp_pkg;

  // Normal vector components carry this many fraction bits.
  localparam int NRM_BITS = 30;

  // Square root: 32 result bits, resolved SQ_STEPS bits per stage.
  localparam int SQ_BITS   = 32;
  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = SQ_BITS / SQ_STEPS;

  // Division: 32 quotient bits, resolved DIV_STEPS bits per stage.
  localparam int DIV_BITS   = 32;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

  // Width of products before rounding and of rounded values.
  localparam int PW = 68;
  localparam int RW = PW - NRM_BITS;

  typedef struct packed {
    logic signed [31:0] area_x;
    logic signed [31:0] area_y;
    logic signed [31:0] area_z;
    logic signed [31:0] g_xx;
    logic signed [31:0] g_xy;
    logic signed [31:0] g_xz;
    logic signed [31:0] g_yx;
    logic signed [31:0] g_yy;
    logic signed [31:0] g_yz;
    logic signed [31:0] g_zx;
    logic signed [31:0] g_zy;
    logic signed [31:0] g_zz;
  } sgp_in_t;

  typedef struct packed {
    logic signed [31:0] c_xx;
    logic signed [31:0] c_xy;
    logic signed [31:0] c_xz;
    logic signed [31:0] c_yx;
    logic signed [31:0] c_yy;
    logic signed [31:0] c_yz;
    logic signed [31:0] c_zx;
    logic signed [31:0] c_zy;
    logic signed [31:0] c_zz;
    logic               zero_area;
  } sgp_out_t;

  // Data that rides along with an item through the normalization stages.
  // Tensor element (row i, column j) sits at index 3*i+j.
  typedef struct packed {
    logic [8:0][31:0] g;
    logic [2:0]       neg;
    logic             zero;
    logic [2:0][31:0] ms;
  } sgp_side_t;

  // Divide by 2^NRM_BITS, rounding to nearest with ties away from zero.
  function automatic logic signed [RW-1:0] round_nrm(logic signed [PW-1:0] v);
    logic [PW-1:0] mag;
    logic [PW-1:0] r;
    mag = v[PW-1] ? (~v + PW'(1)) : v;
    r = (mag + (PW'(1) << (NRM_BITS - 1))) >> NRM_BITS;
    return v[PW-1] ? RW'(-r[RW-1:0]) : r[RW-1:0];
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic [31:0] sat32(logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'h8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

/* rtl/core/sgp_front.sv */
module sgp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  sgp_pkg::sgp_in_t  in_data,
  output logic              out_valid,
  output logic [63:0]       out_sq,
  output sgp_pkg::sgp_side_t out_side
);
  import sgp_pkg::*;

  function automatic logic [5:0] lead_zeros(logic [31:0] x);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) n = 6'(31 - i);
    end
    return n;
  endfunction

  logic [2:0][31:0] a_in;
  logic [2:0][31:0] m_c;
  logic [31:0]      mx_c;

  // Stage 1: magnitudes, signs, largest magnitude.
  logic             v1;
  logic [2:0][31:0] m1;
  logic [2:0]       neg1;
  logic             zero1;
  logic [8:0][31:0] g1;
  logic [31:0]      mx1;

  // Component k of the area vector sits at index k, x first.
  assign a_in = {in_data.area_z, in_data.area_y, in_data.area_x};

  always_comb begin
    mx_c = '0;
    for (int k = 0; k < 3; k++) begin
      m_c[k] = a_in[k][31] ? (~a_in[k] + 32'd1) : a_in[k];
      if (m_c[k] > mx_c) mx_c = m_c[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1    <= m_c;
      mx1   <= mx_c;
      neg1  <= {a_in[2][31], a_in[1][31], a_in[0][31]};
      zero1 <= (in_data.area_x == '0) && (in_data.area_y == '0) && (in_data.area_z == '0);
      g1    <= {in_data.g_zz, in_data.g_zy, in_data.g_zx,
                in_data.g_yz, in_data.g_yy, in_data.g_yx,
                in_data.g_xz, in_data.g_xy, in_data.g_xx};
    end
  end

  // Stage 2: shift all magnitudes so the largest reaches bit 30 or 31.
  logic [5:0]       lz2;
  logic [4:0]       sh2;
  logic             v2;
  sgp_side_t        side2;

  assign lz2 = lead_zeros(mx1);
  assign sh2 = (lz2 == 6'd0) ? 5'd0 : 5'(lz2 - 6'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2.g    <= g1;
      side2.neg  <= neg1;
      side2.zero <= zero1;
      for (int k = 0; k < 3; k++) begin
        side2.ms[k] <= m1[k] << sh2;
      end
    end
  end

  // Stage 3: squares of the shifted magnitudes.
  logic             v3;
  sgp_side_t        side3;
  logic [2:0][63:0] sq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= side2;
      for (int k = 0; k < 3; k++) begin
        sq3[k] <= 64'(side2.ms[k]) * 64'(side2.ms[k]);
      end
    end
  end

  // Stage 4: sum of squares.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side <= side3;
      out_sq   <= sq3[0] + sq3[1] + sq3[2];
    end
  end

endmodule

/* rtl/core/sgp_sqrt.sv */
module sgp_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [63:0]        in_sq,
  input  sgp_pkg::sgp_side_t in_side,
  output logic               out_valid,
  output logic [31:0]        out_root,
  output sgp_pkg::sgp_side_t out_side
);
  import sgp_pkg::*;

  logic        v_r    [SQ_STAGES];
  logic [35:0] rem_r  [SQ_STAGES];
  logic [31:0] root_r [SQ_STAGES];
  logic [63:0] sq_r   [SQ_STAGES];
  sgp_side_t   side_r [SQ_STAGES];

  // Digit-by-digit square root, two result bits per stage.
  for (genvar st = 0; st < SQ_STAGES; st++) begin : g_stage
    logic        v_i;
    logic [35:0] rem_i;
    logic [31:0] root_i;
    logic [63:0] sq_i;
    sgp_side_t   side_i;
    logic [35:0] rem_c;
    logic [31:0] root_c;

    if (st == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign sq_i   = in_sq;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[st-1];
      assign rem_i  = rem_r[st-1];
      assign root_i = root_r[st-1];
      assign sq_i   = sq_r[st-1];
      assign side_i = side_r[st-1];
    end

    always_comb begin
      logic [35:0] shifted;
      logic [35:0] trial;
      int          k;
      rem_c  = rem_i;
      root_c = root_i;
      for (int j = 0; j < SQ_STEPS; j++) begin
        k = SQ_BITS - 1 - st * SQ_STEPS - j;
        shifted = {rem_c[33:0], sq_i[2*k +: 2]};
        trial   = {2'b00, root_c, 2'b01};
        if (shifted >= trial) begin
          rem_c  = shifted - trial;
          root_c = {root_c[30:0], 1'b1};
        end else begin
          rem_c  = shifted;
          root_c = {root_c[30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[st] <= 1'b0;
      end else if (en) begin
        v_r[st] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[st]  <= rem_c;
        root_r[st] <= root_c;
        sq_r[st]   <= sq_i;
        side_r[st] <= side_i;
      end
    end
  end

  assign out_valid = v_r[SQ_STAGES-1];
  assign out_root  = root_r[SQ_STAGES-1];
  assign out_side  = side_r[SQ_STAGES-1];

endmodule

/* rtl/core/sgp_div.sv */
module sgp_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        in_root,
  input  sgp_pkg::sgp_side_t in_side,
  output logic               out_valid,
  output logic [2:0][31:0]   out_n,
  output sgp_pkg::sgp_side_t out_side
);
  import sgp_pkg::*;

  // Entry stage: rounded dividends ms * 2^30 + root / 2.
  logic             v0;
  logic [2:0][62:0] d0;
  logic [31:0]      r0;
  sgp_side_t        side0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0    <= in_root;
      side0 <= in_side;
      for (int k = 0; k < 3; k++) begin
        d0[k] <= {1'b0, in_side.ms[k], 30'd0} + 63'(in_root >> 1);
      end
    end
  end

  logic             v_r    [DIV_STAGES];
  logic [2:0][31:0] rem_r  [DIV_STAGES];
  logic [2:0][31:0] quo_r  [DIV_STAGES];
  logic [2:0][31:0] lo_r   [DIV_STAGES];
  logic [31:0]      r_r    [DIV_STAGES];
  sgp_side_t        side_r [DIV_STAGES];

  // Restoring division in three lanes, two quotient bits per stage.
  for (genvar st = 0; st < DIV_STAGES; st++) begin : g_stage
    logic             v_i;
    logic [2:0][31:0] rem_i;
    logic [2:0][31:0] quo_i;
    logic [2:0][31:0] lo_i;
    logic [31:0]      r_i;
    sgp_side_t        side_i;
    logic [2:0][31:0] rem_c;
    logic [2:0][31:0] quo_c;

    if (st == 0) begin : g_first
      assign v_i    = v0;
      assign r_i    = r0;
      assign side_i = side0;
      assign quo_i  = '0;
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign rem_i[k] = {1'b0, d0[k][62:32]};
        assign lo_i[k]  = d0[k][31:0];
      end
    end else begin : g_next
      assign v_i    = v_r[st-1];
      assign rem_i  = rem_r[st-1];
      assign quo_i  = quo_r[st-1];
      assign lo_i   = lo_r[st-1];
      assign r_i    = r_r[st-1];
      assign side_i = side_r[st-1];
    end

    always_comb begin
      logic [32:0] shifted;
      int          b;
      rem_c = rem_i;
      quo_c = quo_i;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < DIV_STEPS; j++) begin
          b = DIV_BITS - 1 - st * DIV_STEPS - j;
          shifted = {rem_c[k], lo_i[k][b]};
          if (shifted >= {1'b0, r_i}) begin
            rem_c[k] = 32'(shifted - {1'b0, r_i});
            quo_c[k] = {quo_c[k][30:0], 1'b1};
          end else begin
            rem_c[k] = shifted[31:0];
            quo_c[k] = {quo_c[k][30:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[st] <= 1'b0;
      end else if (en) begin
        v_r[st] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[st]  <= rem_c;
        quo_r[st]  <= quo_c;
        lo_r[st]   <= lo_i;
        r_r[st]    <= r_i;
        side_r[st] <= side_i;
      end
    end
  end

  // Apply the signs of the area components.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out_n[k] = side_r[DIV_STAGES-1].neg[k] ? (~quo_r[DIV_STAGES-1][k] + 32'd1)
                                              : quo_r[DIV_STAGES-1][k];
    end
  end

  assign out_valid = v_r[DIV_STAGES-1];
  assign out_side  = side_r[DIV_STAGES-1];

endmodule

/* rtl/core/sgp_proj.sv */
module sgp_proj (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2:0][31:0]   in_n,
  input  sgp_pkg::sgp_side_t in_side,
  output logic               out_valid,
  output sgp_pkg::sgp_out_t  out_data
);
  import sgp_pkg::*;

  // Stage 1: products of the tensor with the normal, and n n.
  logic               v1;
  logic signed [63:0] pr1 [3][3];
  logic signed [63:0] pc1 [3][3];
  logic signed [63:0] nnp1 [3][3];
  logic signed [31:0] n1 [3];
  logic [8:0][31:0]   g1;
  logic               z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g1 <= in_side.g;
      z1 <= in_side.zero;
      for (int i = 0; i < 3; i++) begin
        n1[i] <= $signed(in_n[i]);
        for (int j = 0; j < 3; j++) begin
          pr1[i][j]  <= $signed(in_side.g[i*3+j]) * $signed(in_n[j]);
          pc1[i][j]  <= $signed(in_side.g[j*3+i]) * $signed(in_n[j]);
          nnp1[i][j] <= $signed(in_n[i]) * $signed(in_n[j]);
        end
      end
    end
  end

  // Stage 2: G n, G^T n and n n, rounded.
  logic                 v2;
  logic signed [RW-1:0] gn2 [3];
  logic signed [RW-1:0] gt2 [3];
  logic signed [RW-1:0] nn2 [3][3];
  logic signed [31:0]   n2 [3];
  logic [8:0][31:0]     g2;
  logic                 z2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g2 <= g1;
      z2 <= z1;
      for (int i = 0; i < 3; i++) begin
        n2[i]  <= n1[i];
        gn2[i] <= round_nrm(PW'(pr1[i][0]) + PW'(pr1[i][1]) + PW'(pr1[i][2]));
        gt2[i] <= round_nrm(PW'(pc1[i][0]) + PW'(pc1[i][1]) + PW'(pc1[i][2]));
        for (int j = 0; j < 3; j++) begin
          nn2[i][j] <= round_nrm(PW'(nnp1[i][j]));
        end
      end
    end
  end

  // Stage 3: products for q and for the two outer-product terms.
  logic                 v3;
  logic signed [PW-1:0] qp3 [3];
  logic signed [PW-1:0] a3 [3][3];
  logic signed [PW-1:0] b3 [3][3];
  logic signed [RW-1:0] nn3 [3][3];
  logic [8:0][31:0]     g3;
  logic                 z3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g3  <= g2;
      z3  <= z2;
      nn3 <= nn2;
      for (int i = 0; i < 3; i++) begin
        qp3[i] <= gt2[i] * n2[i];
        for (int j = 0; j < 3; j++) begin
          a3[i][j] <= gn2[i] * n2[j];
          b3[i][j] <= n2[i] * gt2[j];
        end
      end
    end
  end

  // Stage 4: q and the rounded outer-product terms.
  logic                 v4;
  logic signed [RW-1:0] q4;
  logic signed [RW-1:0] ra4 [3][3];
  logic signed [RW-1:0] rb4 [3][3];
  logic signed [RW-1:0] nn4 [3][3];
  logic [8:0][31:0]     g4;
  logic                 z4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g4  <= g3;
      z4  <= z3;
      nn4 <= nn3;
      q4  <= round_nrm(qp3[0] + qp3[1] + qp3[2]);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ra4[i][j] <= round_nrm(a3[i][j]);
          rb4[i][j] <= round_nrm(b3[i][j]);
        end
      end
    end
  end

  // Stage 5: q times n n.
  logic                 v5;
  logic signed [PW-1:0] e5 [3][3];
  logic signed [RW-1:0] ra5 [3][3];
  logic signed [RW-1:0] rb5 [3][3];
  logic [8:0][31:0]     g5;
  logic                 z5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g5  <= g4;
      z5  <= z4;
      ra5 <= ra4;
      rb5 <= rb4;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          e5[i][j] <= q4 * nn4[i][j];
        end
      end
    end
  end

  // Stage 6: combine, saturate, or pass the tensor through for a zero area.
  logic [8:0][31:0] c_c;

  always_comb begin
    logic signed [39:0] acc;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        acc = 40'($signed(g5[i*3+j])) - 40'(ra5[i][j]) - 40'(rb5[i][j])
            + (40'(round_nrm(e5[i][j])) <<< 1);
        c_c[i*3+j] = z5 ? g5[i*3+j] : sat32(acc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.c_xx      <= c_c[0];
      out_data.c_xy      <= c_c[1];
      out_data.c_xz      <= c_c[2];
      out_data.c_yx      <= c_c[3];
      out_data.c_yy      <= c_c[4];
      out_data.c_yz      <= c_c[5];
      out_data.c_zx      <= c_c[6];
      out_data.c_zy      <= c_c[7];
      out_data.c_zz      <= c_c[8];
      out_data.zero_area <= z5;
    end
  end

endmodule

/* rtl/core/symmetry_gradient_projection_unit.sv */
// Projects a boundary node's gradient tensor onto a symmetry plane: from the
// area vector it forms the unit normal n and returns G - (Gn)n - n(G^T n) +
// 2(n^T G n)nn in saturated Q16.16, or G unchanged with zero_area set when
// the area is zero. The block is a 43-stage pipeline (4 normalization front
// stages, 16 square-root stages, 17 division stages, 6 projection stages) and
// takes one node per cycle while the output side does not stall. A stall on
// the result channel freezes the whole pipeline, so node_ready follows
// res_ready while a result is pending.
module symmetry_gradient_projection_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              node_valid,
  output logic              node_ready,
  input  sgp_pkg::sgp_in_t  node,
  output logic              res_valid,
  input  logic              res_ready,
  output sgp_pkg::sgp_out_t res
);
  import sgp_pkg::*;

  logic        en;
  logic        fr_valid;
  logic [63:0] fr_sq;
  sgp_side_t   fr_side;
  logic        sq_valid;
  logic [31:0] sq_root;
  sgp_side_t   sq_side;
  logic        dv_valid;
  logic [2:0][31:0] dv_n;
  sgp_side_t   dv_side;

  // The pipeline advances whenever the output register is free or drained.
  assign en         = !res_valid || res_ready;
  assign node_ready = en;

  sgp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (node_valid),
    .in_data   (node),
    .out_valid (fr_valid),
    .out_sq    (fr_sq),
    .out_side  (fr_side)
  );

  sgp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_valid),
    .in_sq     (fr_sq),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  sgp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_n     (dv_n),
    .out_side  (dv_side)
  );

  sgp_proj u_proj (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv_valid),
    .in_n      (dv_n),
    .in_side   (dv_side),
    .out_valid (res_valid),
    .out_data  (res)
  );

endmodule

/* rtl/core/sgp_checker.sv */
module sgp_checker (
  input logic              clk,
  input logic              rst,
  input logic              node_valid,
  input logic              node_ready,
  input logic              res_valid,
  input logic              res_ready,
  input sgp_pkg::sgp_out_t res
);

  // A pending result is held until its transaction completes.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before its transaction completed");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res))
    else $error("result changed while stalled");

  // A stalled result backs up the whole pipeline to the input.
  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !node_ready)
    else $error("input accepted while the pipeline is stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result shown right after reset");

endmodule

bind symmetry_gradient_projection_unit sgp_checker u_sgp_checker (.*);
